// ===== design/bpm_pkg.sv =====
// Shared types and constants of the battery percent monitor.
package bpm_pkg;

    localparam int TIME_W    = 32;
    localparam int SUM_IN_W  = 16;
    localparam int PCT_W     = 7;
    localparam int MV_W      = 16;
    localparam int CAL_ADC_W = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_READ_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_ADC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_MV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MV     = 3'd4;

    localparam logic [CFG_W-1:0]     READ_DELAY_RST = 16'd1000;
    localparam logic [CFG_W-1:0]     CAL_MV_RST     = 16'd3300;
    localparam logic [CAL_ADC_W-1:0] CAL_ADC_RST    = 12'd0;
    localparam logic [CFG_W-1:0]     MAX_MV_RST     = 16'd4200;
    localparam logic [CFG_W-1:0]     MIN_MV_RST     = 16'd3000;

    // samples per reading must be a power of two
    localparam int SAMPLES_PER_READING  = 16;
    localparam int SAMPLE_SHIFT         = $clog2(SAMPLES_PER_READING);
    localparam int AVG_W                = SUM_IN_W - SAMPLE_SHIFT;
    localparam int READINGS_PER_AVERAGE = 60;
    localparam int CNT_W                = 6;
    localparam int PSUM_W               = 13;

    localparam int CAL_FULL_SCALE  = 4096;
    localparam int PCT_LIMIT       = 100;
    localparam int LOW_ENTER_PCT   = 20;
    localparam int LOW_LEAVE_PCT   = 25;
    localparam int DEFAULT_SPAN_MV = 2000;

    // divide by the reading count as a multiply by a rounded-up reciprocal
    localparam int AVG_FRAC  = 20;
    localparam int RECIP_W   = AVG_FRAC + 1;
    localparam int AVG_RECIP = (2**AVG_FRAC + READINGS_PER_AVERAGE - 1) / READINGS_PER_AVERAGE;

    // serial divider
    localparam int DIV_W     = AVG_W + MV_W;
    localparam int DIVR_W    = MV_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                process;
        logic                immediate;
        logic [SUM_IN_W-1:0] sample_sum;
    } evt_t;

    typedef struct packed {
        logic [CFG_W-1:0]     cal_voltage_mv;
        logic [CAL_ADC_W-1:0] cal_adc_reading;
        logic [CFG_W-1:0]     max_voltage_mv;
        logic [CFG_W-1:0]     min_voltage_mv;
    } calib_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== design/bpm_queue.sv =====
// Two-entry event queue between the front and back ends.
module bpm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bpm_pkg::evt_t    push_data,
    input  logic             pop,
    output bpm_pkg::evt_t    pop_data,
    output bpm_pkg::q_status_t q_status
);
    import bpm_pkg::*;

    evt_t              q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign pop_data       = q_mem[rd_ptr_reg];
    assign q_status.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

endmodule

// ===== design/bpm_front.sv =====
// Front end: takes measurement beats and decides which ones are processed.
module bpm_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            meas_valid,
    output logic                            meas_stall,
    input  logic [bpm_pkg::TIME_W-1:0]      now_ms,
    input  logic                            immediate,
    input  logic [bpm_pkg::SUM_IN_W-1:0]    sample_sum,
    input  logic [bpm_pkg::CFG_W-1:0]       read_delay_ms,
    input  bpm_pkg::q_status_t              q_status,
    output logic                            push,
    output bpm_pkg::evt_t                   push_data
);
    import bpm_pkg::*;

    logic [TIME_W-1:0] last_read_time_reg;
    logic [TIME_W-1:0] elapsed;
    logic              process;

    // elapsed time wraps modulo 2^32
    assign elapsed    = now_ms - last_read_time_reg;
    assign process    = (elapsed > TIME_W'(read_delay_ms)) || immediate;
    assign meas_stall = q_status.full;
    assign push       = meas_valid && !q_status.full;

    assign push_data.process    = process;
    assign push_data.immediate  = immediate;
    assign push_data.sample_sum = sample_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_read_time_reg <= '0;
        end
        else if (push && process)
        begin
            last_read_time_reg <= now_ms;
        end
    end

endmodule

// ===== design/bpm_div.sv =====
// Restoring divider, one quotient bit per cycle.
module bpm_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bpm_pkg::DIV_W-1:0]    dividend,
    input  logic [bpm_pkg::DIVR_W-1:0]   divisor,
    output logic                         done,
    output logic [bpm_pkg::DIV_W-1:0]    quotient
);
    import bpm_pkg::*;

    logic [DIV_W-1:0]     q_reg;
    logic [DIVR_W-1:0]    rem_reg;
    logic [DIVR_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic                 fits;

    // shift next dividend bit into the partial remainder
    assign trial = {rem_reg, q_reg[DIV_W-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/bpm_back.sv =====
// Back end: millivolt and percent conversion, averaging, status and result register.
module bpm_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpm_pkg::q_status_t            q_status,
    input  bpm_pkg::evt_t                 pop_data,
    output logic                          pop,
    input  bpm_pkg::calib_t               cal,
    output logic                          div_start,
    output logic [bpm_pkg::DIV_W-1:0]     div_dividend,
    output logic [bpm_pkg::DIVR_W-1:0]    div_divisor,
    input  logic                          div_done,
    input  logic [bpm_pkg::DIV_W-1:0]     div_quotient,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          status_update,
    output logic [bpm_pkg::PCT_W-1:0]     percent,
    output logic                          low_battery,
    output logic [bpm_pkg::MV_W-1:0]      voltage_mv
);
    import bpm_pkg::*;

    localparam int NUM_W  = MV_W + PCT_W;
    localparam int DIFF_W = MV_W + 1;
    localparam int PROD_W = PSUM_W + RECIP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MVDIV,
        S_PCTSET,
        S_PCTDIV,
        S_AVG,
        S_EMIT
    } state_t;

    state_t             state_reg;
    logic               imm_reg;
    logic [DIFF_W-1:0]  diff_reg;
    logic               sign_reg;
    logic [PSUM_W-1:0]  psum_tmp_reg;
    logic [CNT_W-1:0]   reading_count_reg;
    logic [PSUM_W-1:0]  percent_sum_reg;
    logic [PCT_W-1:0]   published_reg;
    logic               status_low_reg;
    logic [MV_W-1:0]    last_voltage_reg;
    logic               upd_reg;
    logic               div_start_reg;
    logic [DIV_W-1:0]   div_dividend_reg;
    logic [DIVR_W-1:0]  div_divisor_reg;
    logic               result_valid_reg;
    logic               status_update_reg;
    logic [PCT_W-1:0]   percent_reg;
    logic               low_battery_reg;
    logic [MV_W-1:0]    voltage_mv_reg;

    logic [DIVR_W-1:0]  cal_eff;
    logic [MV_W-1:0]    mv_sat;
    logic [DIFF_W-1:0]  span_raw;
    logic [DIFF_W-1:0]  span_abs;
    logic [DIVR_W-1:0]  span_mag;
    logic [DIFF_W-1:0]  diff_mag;
    logic [NUM_W-1:0]   num_mag;
    logic [PCT_W-1:0]   pct_val;
    logic [PSUM_W-1:0]  psum_next;
    logic               avg_due;
    logic [PROD_W-1:0]  avg_prod;
    logic [PCT_W-1:0]   avg_val;
    logic               can_emit;

    always_comb
    begin
        cal_eff = (cal.cal_adc_reading == '0) ? DIVR_W'(CAL_FULL_SCALE)
                                              : DIVR_W'(cal.cal_adc_reading);
        mv_sat  = (|div_quotient[DIV_W-1:MV_W]) ? '1 : div_quotient[MV_W-1:0];

        // signed span; a zero span falls back to the default
        span_raw = {1'b0, cal.max_voltage_mv} - {1'b0, cal.min_voltage_mv};
        span_abs = span_raw[DIFF_W-1] ? (DIFF_W'(0) - span_raw) : span_raw;
        span_mag = (span_raw == '0) ? DIVR_W'(DEFAULT_SPAN_MV) : span_abs[DIVR_W-1:0];

        diff_mag = diff_reg[DIFF_W-1] ? (DIFF_W'(0) - diff_reg) : diff_reg;
        num_mag  = NUM_W'(diff_mag[MV_W-1:0]) * NUM_W'(PCT_LIMIT);

        // negative quotient clamps to zero, large one to the limit
        if (sign_reg)
        begin
            pct_val = '0;
        end
        else if (div_quotient > DIV_W'(PCT_LIMIT))
        begin
            pct_val = PCT_W'(PCT_LIMIT);
        end
        else
        begin
            pct_val = div_quotient[PCT_W-1:0];
        end

        psum_next = percent_sum_reg + PSUM_W'(pct_val);
        avg_due   = (({1'b0, reading_count_reg} + 1'b1) >= (CNT_W+1)'(READINGS_PER_AVERAGE));
        avg_prod  = PROD_W'(psum_tmp_reg) * PROD_W'(AVG_RECIP);
        avg_val   = avg_prod[AVG_FRAC +: PCT_W];
        can_emit  = !result_valid_reg || !result_stall;
    end

    assign pop = (state_reg == S_IDLE) && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            reading_count_reg <= '0;
            percent_sum_reg   <= '0;
            published_reg     <= '0;
            status_low_reg    <= 1'b0;
            last_voltage_reg  <= '0;
            div_start_reg     <= 1'b0;
            result_valid_reg  <= 1'b0;
            imm_reg           <= 1'b0;
            upd_reg           <= 1'b0;
            sign_reg          <= 1'b0;
            diff_reg          <= '0;
            psum_tmp_reg      <= '0;
            div_dividend_reg  <= '0;
            div_divisor_reg   <= '0;
            status_update_reg <= 1'b0;
            percent_reg       <= '0;
            low_battery_reg   <= 1'b0;
            voltage_mv_reg    <= '0;
        end
        else
        begin
            // start is a one-cycle pulse; it is never raised from a divide state
            if (div_start_reg)
            begin
                div_start_reg <= 1'b0;
            end
            // the emit state reloads the output register itself
            if (result_valid_reg && !result_stall && (state_reg != S_EMIT))
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (!q_status.empty)
                    begin
                        imm_reg <= pop_data.immediate;
                        if (pop_data.process)
                        begin
                            div_start_reg    <= 1'b1;
                            div_dividend_reg <=
                                DIV_W'(pop_data.sample_sum[SUM_IN_W-1:SAMPLE_SHIFT])
                                * DIV_W'(cal.cal_voltage_mv);
                            div_divisor_reg  <= cal_eff;
                            state_reg        <= S_MVDIV;
                        end
                        else
                        begin
                            upd_reg   <= 1'b0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_MVDIV:
                begin
                    if (div_done)
                    begin
                        last_voltage_reg <= mv_sat;
                        diff_reg  <= {1'b0, mv_sat} - {1'b0, cal.min_voltage_mv};
                        state_reg <= S_PCTSET;
                    end
                end
                S_PCTSET:
                begin
                    sign_reg         <= diff_reg[DIFF_W-1] ^ span_raw[DIFF_W-1];
                    div_start_reg    <= 1'b1;
                    div_dividend_reg <= DIV_W'(num_mag);
                    div_divisor_reg  <= span_mag;
                    state_reg        <= S_PCTDIV;
                end
                S_PCTDIV:
                begin
                    if (div_done)
                    begin
                        if (avg_due)
                        begin
                            psum_tmp_reg <= psum_next;
                            state_reg    <= S_AVG;
                        end
                        else
                        begin
                            reading_count_reg <= reading_count_reg + 1'b1;
                            percent_sum_reg   <= psum_next;
                            upd_reg           <= imm_reg;
                            if (imm_reg)
                            begin
                                published_reg <= pct_val;
                            end
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_AVG:
                begin
                    published_reg     <= avg_val;
                    reading_count_reg <= '0;
                    percent_sum_reg   <= '0;
                    upd_reg           <= 1'b1;
                    // hysteresis between OK and LOW
                    if (!status_low_reg && (avg_val <= PCT_W'(LOW_ENTER_PCT)))
                    begin
                        status_low_reg <= 1'b1;
                    end
                    else if (status_low_reg && (avg_val >= PCT_W'(LOW_LEAVE_PCT)))
                    begin
                        status_low_reg <= 1'b0;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (can_emit)
                    begin
                        result_valid_reg  <= 1'b1;
                        status_update_reg <= upd_reg;
                        percent_reg       <= published_reg;
                        low_battery_reg   <= status_low_reg;
                        voltage_mv_reg    <= last_voltage_reg;
                        state_reg         <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign div_start     = div_start_reg;
    assign div_dividend  = div_dividend_reg;
    assign div_divisor   = div_divisor_reg;
    assign result_valid  = result_valid_reg;
    assign status_update = status_update_reg;
    assign percent       = percent_reg;
    assign low_battery   = low_battery_reg;
    assign voltage_mv    = voltage_mv_reg;

    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        published_reg <= PCT_W'(PCT_LIMIT))
        else $error("published percent above limit");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_MVDIV || state_reg == S_PCTDIV))
        else $error("divider finished outside a divide state");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W+1)'(reading_count_reg) < (CNT_W+1)'(READINGS_PER_AVERAGE))
        else $error("reading count out of range");

    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && can_emit) |=> (result_valid_reg && state_reg == S_IDLE))
        else $error("result beat not loaded");

endmodule

// ===== design/battery_percent_monitor_unit.sv =====
// Battery percent monitor: top level with configuration registers.
//
// Measurement beats enter on meas_valid/meas_stall with now_ms, immediate and
// sample_sum. Every beat yields exactly one result beat on result_valid /
// result_stall, in order. A beat is processed when the wrapped elapsed time
// since the last processed beat exceeds read_delay_ms, or when immediate is set.
// A processed beat holds the back end for pop, a millivolt pass of the shared
// serial divider (start, 28 quotient bits, done), set-up, a percent pass,
// averaging when an average is due, and output load; a skipped beat goes from
// pop straight to output load. One beat per back-end pass: the back end pops
// only when idle. The front end keeps taking beats into a two-entry queue while
// the back end is busy; meas_stall rises only when the queue is full. A stalled
// result waits in the output register and the back end holds its finished beat
// until then. Configuration must be written only while idle, by the user, via
// cfg_we/cfg_index/cfg_data; the block itself does not enforce this. Reset
// restores the default registers, clears the averaging state, the published
// percent (status OK) and empties the queue; no clearing pass.
module battery_percent_monitor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bpm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bpm_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            meas_valid,
    output logic                            meas_stall,
    input  logic [bpm_pkg::TIME_W-1:0]      now_ms,
    input  logic                            immediate,
    input  logic [bpm_pkg::SUM_IN_W-1:0]    sample_sum,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            status_update,
    output logic [bpm_pkg::PCT_W-1:0]       percent,
    output logic                            low_battery,
    output logic [bpm_pkg::MV_W-1:0]        voltage_mv
);
    import bpm_pkg::*;

    logic [CFG_W-1:0]     read_delay_reg;
    logic [CFG_W-1:0]     cal_mv_reg;
    logic [CAL_ADC_W-1:0] cal_adc_reg;
    logic [CFG_W-1:0]     max_mv_reg;
    logic [CFG_W-1:0]     min_mv_reg;

    calib_t               cal;
    q_status_t            q_status;
    logic                 push;
    evt_t                 push_data;
    logic                 pop;
    evt_t                 pop_data;
    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DIVR_W-1:0]    div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            read_delay_reg <= READ_DELAY_RST;
            cal_mv_reg     <= CAL_MV_RST;
            cal_adc_reg    <= CAL_ADC_RST;
            max_mv_reg     <= MAX_MV_RST;
            min_mv_reg     <= MIN_MV_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_READ_DELAY: read_delay_reg <= cfg_data;
                REG_CAL_MV:     cal_mv_reg     <= cfg_data;
                REG_CAL_ADC:    cal_adc_reg    <= cfg_data[CAL_ADC_W-1:0];
                REG_MAX_MV:     max_mv_reg     <= cfg_data;
                REG_MIN_MV:     min_mv_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign cal.cal_voltage_mv  = cal_mv_reg;
    assign cal.cal_adc_reading = cal_adc_reg;
    assign cal.max_voltage_mv  = max_mv_reg;
    assign cal.min_voltage_mv  = min_mv_reg;

    bpm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .meas_valid    (meas_valid),
        .meas_stall    (meas_stall),
        .now_ms        (now_ms),
        .immediate     (immediate),
        .sample_sum    (sample_sum),
        .read_delay_ms (read_delay_reg),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    bpm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    bpm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bpm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .pop_data      (pop_data),
        .pop           (pop),
        .cal           (cal),
        .div_start     (div_start),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_done      (div_done),
        .div_quotient  (div_quotient),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .status_update (status_update),
        .percent       (percent),
        .low_battery   (low_battery),
        .voltage_mv    (voltage_mv)
    );

endmodule
